>>> rtl/core/kuz_pkg.sv
// Package for the 128-bit block cipher core: opcodes, S-boxes, GF(2^8) multiply
// and the L / L^-1 linear layers. No dependencies.
`default_nettype none
package kuz_pkg;

   localparam int NumRoundKeysDefault = 10;
   localparam int CoreRounds = 9;
   localparam logic [7:0] GfPoly = 8'hc3;
   localparam logic [7:0] GfTop = 8'h80;

   typedef enum logic [1:0] {
      OP_WRKEY = 2'd0,
      OP_ENC   = 2'd1,
      OP_DEC   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] block_type;

   localparam byte_type PiBox [256] = '{
      252, 238, 221, 17, 207, 110, 49, 22, 251, 196, 250, 218, 35, 197, 4, 77,
      233, 119, 240, 219, 147, 46, 153, 186, 23, 54, 241, 187, 20, 205, 95, 193,
      249, 24, 101, 90, 226, 92, 239, 33, 129, 28, 60, 66, 139, 1, 142, 79,
      5, 132, 2, 174, 227, 106, 143, 160, 6, 11, 237, 152, 127, 212, 211, 31,
      235, 52, 44, 81, 234, 200, 72, 171, 242, 42, 104, 162, 253, 58, 206, 204,
      181, 112, 14, 86, 8, 12, 118, 18, 191, 114, 19, 71, 156, 183, 93, 135,
      21, 161, 150, 41, 16, 123, 154, 199, 243, 145, 120, 111, 157, 158, 178, 177,
      50, 117, 25, 61, 255, 53, 138, 126, 109, 84, 198, 128, 195, 189, 13, 87,
      223, 245, 36, 169, 62, 168, 67, 201, 215, 121, 214, 246, 124, 34, 185, 3,
      224, 15, 236, 222, 122, 148, 176, 188, 220, 232, 40, 80, 78, 51, 10, 74,
      167, 151, 96, 115, 30, 0, 98, 68, 26, 184, 56, 130, 100, 159, 38, 65,
      173, 69, 70, 146, 39, 94, 85, 47, 140, 163, 165, 125, 105, 213, 149, 59,
      7, 88, 179, 64, 134, 172, 29, 247, 48, 55, 107, 228, 136, 217, 231, 137,
      225, 27, 131, 73, 76, 63, 248, 254, 141, 83, 170, 144, 202, 216, 133, 97,
      32, 113, 103, 164, 45, 43, 9, 91, 203, 155, 37, 208, 190, 229, 108, 82,
      89, 166, 116, 210, 230, 244, 180, 192, 209, 102, 175, 194, 57, 75, 99, 182
   };

   localparam byte_type LfsrCoef [16] = '{
      1, 148, 32, 133, 16, 194, 192, 1, 251, 1, 192, 194, 16, 133, 32, 148
   };

   function automatic byte_type pi_inv(input byte_type v);
      byte_type r;
      r = '0;
      for (int k = 0; k < 256; k++) begin
         if (PiBox[k] == v) begin
            r = byte_type'(k);
         end
      end
      return r;
   endfunction

   function automatic byte_type gf_mul(input byte_type x, input byte_type y);
      byte_type acc;
      byte_type p;
      acc = '0;
      p = x;
      for (int n = 0; n < 8; n++) begin
         if (y[n]) begin
            acc = acc ^ p;
         end
         p = (p & GfTop) != '0 ? ((p << 1) ^ GfPoly) : (p << 1);
      end
      return acc;
   endfunction

   function automatic block_type lin_fwd(input block_type blk);
      block_type b;
      byte_type fb;
      b = blk;
      for (int j = 0; j < 16; j++) begin
         fb = '0;
         for (int i = 0; i < 16; i++) begin
            fb = fb ^ gf_mul(b[8*i +: 8], LfsrCoef[i]);
         end
         b = {fb, b[127:8]};
      end
      return b;
   endfunction

   function automatic block_type lin_bwd(input block_type blk);
      block_type b;
      byte_type fb;
      b = blk;
      for (int j = 0; j < 16; j++) begin
         b = {b[119:0], b[127:120]};
         fb = b[7:0];
         for (int i = 1; i < 16; i++) begin
            fb = fb ^ gf_mul(b[8*i +: 8], LfsrCoef[i]);
         end
         b[7:0] = fb;
      end
      return b;
   endfunction

   function automatic block_type sub_fwd(input block_type blk);
      block_type b;
      for (int i = 0; i < 16; i++) begin
         b[8*i +: 8] = PiBox[blk[8*i +: 8]];
      end
      return b;
   endfunction

   function automatic block_type sub_bwd(input block_type blk);
      block_type b;
      for (int i = 0; i < 16; i++) begin
         b[8*i +: 8] = pi_inv(blk[8*i +: 8]);
      end
      return b;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/kuz_round.sv
// One pipeline stage: key XOR, S-box and linear layer (forward or inverse).
// Depends on kuz_pkg.
`default_nettype none
module kuz_round
   import kuz_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire logic      in_valid,
   input  wire logic      in_dec,
   input  wire block_type in_data,
   input  wire block_type in_key,
   output logic           out_valid,
   output logic           out_dec,
   output block_type      out_data
);
   block_type data_in;
   logic valid_ff;
   logic dec_ff;
   block_type data_ff;

   always_comb begin
      if (in_dec) begin
         data_in = sub_bwd(lin_bwd(in_data)) ^ in_key;
      end else begin
         data_in = lin_fwd(sub_fwd(in_data ^ in_key));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         dec_ff <= in_dec;
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dec = dec_ff;
   assign out_data = data_ff;
endmodule
`default_nettype wire

>>> rtl/core/kuznyechik_block_cipher_core.sv
// Top level of the 128-bit block cipher core: round key registers, nine round
// stages and the output register. Depends on kuz_pkg and kuz_round.
//
// Usage: req_ beats carry an operation, a key slot and a 128-bit block.
// Operation 0 writes the 64-bit key half data_high into slot key_slot and
// gives no rsp_ beat; 1 encrypts, 2 decrypts; 3 and out-of-range slots drop.
// Each encrypt or decrypt yields one rsp_ beat, in request order.
// From the accepting edge a block passes the input register, which loads at
// that edge, then the nine round stages and the output stage to rsp_valid.
// One block per cycle when not stalled; each round is its own register stage.
// The whole pipe advances when the output register is empty or being taken;
// a stalled receiver freezes every stage and holds req_ready low.
// A key write waits with req_ready low until no block is left in the input
// or round stages, so every block sees the keys that stood when it was
// accepted. Reset clears valid bits only; round keys are undefined until
// written.
`default_nettype none
module kuznyechik_block_cipher_core
   import kuz_pkg::*;
#(
   parameter int NUM_ROUND_KEYS = NumRoundKeysDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [4:0]  req_key_slot,
   input  wire logic [63:0] req_data_high,
   input  wire logic [63:0] req_data_low,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result_high,
   output logic [63:0]      rsp_result_low
);
   localparam int Halves = 2 * NUM_ROUND_KEYS;
   localparam int Stages = NUM_ROUND_KEYS - 1;

   logic [63:0] key_ff [Halves];
   block_type rk [NUM_ROUND_KEYS];
   logic advance;
   logic accept;
   logic busy;
   op_type op;

   logic in_valid_ff;
   logic in_dec_ff;
   block_type in_data_ff;

   logic st_valid [Stages+1];
   logic st_dec [Stages+1];
   block_type st_data [Stages+1];

   logic out_valid_ff;
   block_type out_data_ff;
   block_type final_key;

   assign op = op_type'(req_operation);
   assign advance = !out_valid_ff || rsp_ready;

   always_comb begin
      busy = in_valid_ff;
      for (int s = 1; s <= Stages; s++) begin
         busy = busy || st_valid[s];
      end
   end

   assign req_ready = advance && !(op == OP_WRKEY && busy);
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (accept && op == OP_WRKEY && 32'(req_key_slot) < Halves) begin
         key_ff[req_key_slot] <= req_data_high;
      end
   end

   for (genvar k = 0; k < NUM_ROUND_KEYS; k++) begin : g_rk
      assign rk[k] = {key_ff[2*k+1], key_ff[2*k]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= accept && (op == OP_ENC || op == OP_DEC);
      end
      if (advance) begin
         in_dec_ff <= op == OP_DEC;
         in_data_ff <= {req_data_high, req_data_low};
      end
   end

   assign st_valid[0] = in_valid_ff;
   assign st_dec[0] = in_dec_ff;
   assign st_data[0] = in_dec_ff ? (in_data_ff ^ rk[NUM_ROUND_KEYS-1]) : in_data_ff;

   for (genvar s = 0; s < Stages; s++) begin : g_st
      kuz_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (st_valid[s]),
         .in_dec    (st_dec[s]),
         .in_data   (st_data[s]),
         .in_key    (st_dec[s] ? rk[Stages-1-s] : rk[s]),
         .out_valid (st_valid[s+1]),
         .out_dec   (st_dec[s+1]),
         .out_data  (st_data[s+1])
      );
   end

   assign final_key = st_dec[Stages] ? '0 : rk[NUM_ROUND_KEYS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= st_valid[Stages];
      end
      if (advance) begin
         out_data_ff <= st_data[Stages] ^ final_key;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result_high = out_data_ff[127:64];
   assign rsp_result_low = out_data_ff[63:0];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_data_ff))
      else $error("result changed while stalled");
   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken during stall");
   a_key_nores: assert property (@(posedge clock) disable iff (reset)
      accept && op == OP_WRKEY |=> !in_valid_ff)
      else $error("key write made a block");
   a_key_idle: assert property (@(posedge clock) disable iff (reset)
      accept && op == OP_WRKEY |-> !busy)
      else $error("key write with blocks in flight");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      advance && st_valid[Stages] |=> out_valid_ff)
      else $error("block lost at output");
endmodule
`default_nettype wire
